// ===== hw/rtl/pidc_pkg.sv =====
// Shared types, codes and helpers for the PID controller step block.
package pidc_pkg;

   // Register indexes on the configuration port
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_KP_GAIN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KI_GAIN      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KD_GAIN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WIND_MIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WIND_MAX     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CLAMP_ENABLE = 3'd5;

   // Datapath command codes issued by the sequencer
   localparam int unsigned CMD_W = 4;
   localparam logic [CMD_W-1:0] CMD_NONE      = 4'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD      = 4'd1;
   localparam logic [CMD_W-1:0] CMD_MUL_KDT   = 4'd2;
   localparam logic [CMD_W-1:0] CMD_KDT_SAT   = 4'd3;
   localparam logic [CMD_W-1:0] CMD_MUL_INC   = 4'd4;
   localparam logic [CMD_W-1:0] CMD_ACC_SUM   = 4'd5;
   localparam logic [CMD_W-1:0] CMD_ACC_CLAMP = 4'd6;
   localparam logic [CMD_W-1:0] CMD_MUL_P     = 4'd7;
   localparam logic [CMD_W-1:0] CMD_P_SAVE    = 4'd8;
   localparam logic [CMD_W-1:0] CMD_MUL_D     = 4'd9;
   localparam logic [CMD_W-1:0] CMD_MAG_SAVE  = 4'd10;
   localparam logic [CMD_W-1:0] CMD_DIV_INIT  = 4'd11;
   localparam logic [CMD_W-1:0] CMD_DIV_STEP  = 4'd12;
   localparam logic [CMD_W-1:0] CMD_FINISH    = 4'd13;

   typedef logic [CMD_W-1:0] pidc_cmd_type;

   // Derivative divider: quotient bits produced one per step
   localparam int unsigned DIV_STEPS = 49;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_STEPS-1:0] D_LIMIT = {1'b1, {(DIV_STEPS-1){1'b0}}};

   // Width of the wide signed values handed to the saturator
   localparam int unsigned WIDE_W = 66;

   typedef struct packed {
      logic signed [31:0] kp_gain;
      logic signed [31:0] ki_gain;
      logic signed [31:0] kd_gain;
      logic signed [31:0] wind_min;
      logic signed [31:0] wind_max;
      logic               clamp_enable;
   } pidc_cfg_type;

   typedef struct packed {
      logic div_skip;   // no divider steps needed for this beat
      logic rsp_busy;   // result register holds a stalled beat
   } pidc_stat_type;

   // True when a wide signed value lies outside the signed 32-bit range
   function automatic logic pidc_ovf32(input logic signed [WIDE_W-1:0] v);
      return !((&v[WIDE_W-1:31]) || !(|v[WIDE_W-1:31]));
   endfunction

   // Saturate a wide signed value to the signed 32-bit range
   function automatic logic signed [31:0] pidc_sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [31:0] res;
      if (!pidc_ovf32(v)) begin
         res = v[31:0];
      end else if (v[WIDE_W-1]) begin
         res = {1'b1, {31{1'b0}}};
      end else begin
         res = {1'b0, {31{1'b1}}};
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/pidc_csr.sv =====
// Configuration registers of the PID controller step block.
module pidc_csr
   import pidc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output pidc_cfg_type         cfg
);

   pidc_cfg_type cfg_ff;
   pidc_cfg_type cfg_in;

   // Decode the write; unknown indexes drop the beat
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_KP_GAIN:      cfg_in.kp_gain      = csr_wdata;
            REG_KI_GAIN:      cfg_in.ki_gain      = csr_wdata;
            REG_KD_GAIN:      cfg_in.kd_gain      = csr_wdata;
            REG_WIND_MIN:     cfg_in.wind_min     = csr_wdata;
            REG_WIND_MAX:     cfg_in.wind_max     = csr_wdata;
            REG_CLAMP_ENABLE: cfg_in.clamp_enable = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_gain      <= '0;
         cfg_ff.ki_gain      <= '0;
         cfg_ff.kd_gain      <= '0;
         cfg_ff.wind_min     <= {1'b1, {31{1'b0}}};
         cfg_ff.wind_max     <= {1'b0, {31{1'b1}}};
         cfg_ff.clamp_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/pidc_datapath.sv =====
// Datapath: shared multiplier, integral state, restoring divider, result register.
module pidc_datapath
   import pidc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  pidc_cfg_type        cfg,
   input  pidc_cmd_type        cmd,
   output pidc_stat_type       stat,
   input  logic signed [31:0]  req_error_sample,
   input  logic [31:0]         req_step_time,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_drive_value,
   output logic                rsp_out_saturated
);

   // Item operands
   logic signed [31:0]        err_ff, err_in;
   logic [31:0]               dt_ff, dt_in;
   logic signed [31:0]        avg_ff, avg_in;
   logic signed [32:0]        diff_ff, diff_in;
   // Loop state
   logic signed [31:0]        last_err_ff, last_err_in;
   logic signed [31:0]        integ_ff, integ_in;
   // Intermediate terms
   logic signed [WIDE_W-1:0]  prod_ff, prod_in;
   logic signed [31:0]        kdt_ff, kdt_in;
   logic signed [31:0]        acc_ff, acc_in;
   logic signed [49:0]        p_ff, p_in;
   logic                      neg_ff, neg_in;
   logic [63:0]               mag_ff, mag_in;
   // Divider
   logic [31:0]               rem_ff, rem_in;
   logic [DIV_STEPS-1:0]      quo_ff, quo_in;
   // Result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]        rsp_drive_ff, rsp_drive_in;
   logic                      rsp_sat_ff, rsp_sat_in;

   logic signed [32:0]        mul_a;
   logic signed [32:0]        mul_b;
   logic signed [32:0]        err_ext;
   logic signed [32:0]        prev_ext;
   logic signed [32:0]        pair_sum;
   logic signed [WIDE_W-1:0]  acc_sum;
   logic signed [31:0]        clamp_lo;
   logic [WIDE_W-1:0]         prod_mag;
   logic                      dt_zero;
   logic                      div_ovf;
   logic [32:0]               trial;
   logic [32:0]               trial_sub;
   logic                      trial_ge;
   logic [DIV_STEPS-1:0]      q_lim;
   logic signed [WIDE_W-1:0]  d_term;
   logic signed [WIDE_W-1:0]  y_sum;

   // Pick multiplier operands for the current step
   always_comb begin
      unique case (cmd)
         CMD_MUL_KDT: begin
            mul_a = {cfg.ki_gain[31], cfg.ki_gain};
            mul_b = {1'b0, dt_ff};
         end
         CMD_MUL_INC: begin
            mul_a = {kdt_ff[31], kdt_ff};
            mul_b = {avg_ff[31], avg_ff};
         end
         CMD_MUL_P: begin
            mul_a = {cfg.kp_gain[31], cfg.kp_gain};
            mul_b = {err_ff[31], err_ff};
         end
         CMD_MUL_D: begin
            mul_a = {cfg.kd_gain[31], cfg.kd_gain};
            mul_b = diff_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign err_ext  = {req_error_sample[31], req_error_sample};
   assign prev_ext = {last_err_ff[31], last_err_ff};
   assign pair_sum = err_ext + prev_ext;

   assign acc_sum  = {{(WIDE_W-32){integ_ff[31]}}, integ_ff}
                   + {{16{prod_ff[WIDE_W-1]}}, prod_ff[WIDE_W-1:16]};
   assign clamp_lo = (acc_ff < cfg.wind_min) ? cfg.wind_min : acc_ff;
   assign prod_mag = prod_ff[WIDE_W-1] ? (WIDE_W'(0) - prod_ff) : prod_ff;

   assign dt_zero  = (dt_ff == '0);
   assign div_ovf  = ({17'd0, mag_ff[63:DIV_STEPS]} >= dt_ff);

   assign trial     = {rem_ff, quo_ff[DIV_STEPS-1]};
   assign trial_sub = trial - {1'b0, dt_ff};
   assign trial_ge  = (trial >= {1'b0, dt_ff});

   // Limit the derivative magnitude, restore the sign, sum the three terms
   assign q_lim  = (quo_ff > D_LIMIT) ? D_LIMIT : quo_ff;
   assign d_term = neg_ff ? (WIDE_W'(0) - {{(WIDE_W-DIV_STEPS){1'b0}}, q_lim})
                          : {{(WIDE_W-DIV_STEPS){1'b0}}, q_lim};
   assign y_sum  = {{(WIDE_W-50){p_ff[49]}}, p_ff}
                 + {{(WIDE_W-32){integ_ff[31]}}, integ_ff}
                 + d_term;

   // Next values of all datapath registers
   always_comb begin
      err_in       = err_ff;
      dt_in        = dt_ff;
      avg_in       = avg_ff;
      diff_in      = diff_ff;
      last_err_in  = last_err_ff;
      integ_in     = integ_ff;
      prod_in      = prod_ff;
      kdt_in       = kdt_ff;
      acc_in       = acc_ff;
      p_in         = p_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (cmd)
         CMD_LOAD: begin
            err_in      = req_error_sample;
            dt_in       = req_step_time;
            avg_in      = pair_sum[32:1];
            diff_in     = err_ext - prev_ext;
            last_err_in = req_error_sample;
         end
         CMD_MUL_KDT, CMD_MUL_INC, CMD_MUL_P, CMD_MUL_D: begin
            prod_in = WIDE_W'(mul_a) * WIDE_W'(mul_b);
         end
         CMD_KDT_SAT: begin
            kdt_in = pidc_sat32({{16{prod_ff[WIDE_W-1]}}, prod_ff[WIDE_W-1:16]});
         end
         CMD_ACC_SUM: begin
            acc_in = pidc_sat32(acc_sum);
         end
         CMD_ACC_CLAMP: begin
            if (cfg.clamp_enable) begin
               integ_in = (clamp_lo > cfg.wind_max) ? cfg.wind_max : clamp_lo;
            end else begin
               integ_in = acc_ff;
            end
         end
         CMD_P_SAVE: begin
            p_in = prod_ff[WIDE_W-1:16];
         end
         CMD_MAG_SAVE: begin
            neg_in = prod_ff[WIDE_W-1];
            mag_in = prod_mag[63:0];
         end
         CMD_DIV_INIT: begin
            priority if (dt_zero) begin
               quo_in = '0;
            end else if (div_ovf) begin
               quo_in = D_LIMIT;
            end else begin
               rem_in = {17'd0, mag_ff[63:DIV_STEPS]};
               quo_in = mag_ff[DIV_STEPS-1:0];
            end
         end
         CMD_DIV_STEP: begin
            rem_in = trial_ge ? trial_sub[31:0] : trial[31:0];
            quo_in = {quo_ff[DIV_STEPS-2:0], trial_ge};
         end
         CMD_FINISH: begin
            rsp_drive_in = pidc_sat32(y_sum);
            rsp_sat_in   = pidc_ovf32(y_sum);
            rsp_valid_in = 1'b1;
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   // Loop state and result valid take reset; payload registers do not
   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff  <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_err_ff  <= last_err_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      dt_ff        <= dt_in;
      avg_ff       <= avg_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      kdt_ff       <= kdt_in;
      acc_ff       <= acc_in;
      p_ff         <= p_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign stat.div_skip = dt_zero || div_ovf;
   assign stat.rsp_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_value   = rsp_drive_ff;
   assign rsp_out_saturated = rsp_sat_ff;

endmodule

// ===== hw/rtl/pidc_ctrl.sv =====
// Sequencer: steps the datapath through one controller update per input beat.
module pidc_ctrl
   import pidc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  pidc_stat_type stat,
   output pidc_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_MUL_KDT   = 4'd1;
   localparam logic [3:0] S_KDT_SAT   = 4'd2;
   localparam logic [3:0] S_MUL_INC   = 4'd3;
   localparam logic [3:0] S_ACC_SUM   = 4'd4;
   localparam logic [3:0] S_ACC_CLAMP = 4'd5;
   localparam logic [3:0] S_MUL_P     = 4'd6;
   localparam logic [3:0] S_P_SAVE    = 4'd7;
   localparam logic [3:0] S_MUL_D     = 4'd8;
   localparam logic [3:0] S_MAG_SAVE  = 4'd9;
   localparam logic [3:0] S_DIV_INIT  = 4'd10;
   localparam logic [3:0] S_DIV_STEP  = 4'd11;
   localparam logic [3:0] S_FINISH    = 4'd12;

   logic [3:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // Advance the sequence and issue the matching datapath command
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd      = CMD_LOAD;
               state_in = S_MUL_KDT;
            end
         end
         S_MUL_KDT: begin
            cmd      = CMD_MUL_KDT;
            state_in = S_KDT_SAT;
         end
         S_KDT_SAT: begin
            cmd      = CMD_KDT_SAT;
            state_in = S_MUL_INC;
         end
         S_MUL_INC: begin
            cmd      = CMD_MUL_INC;
            state_in = S_ACC_SUM;
         end
         S_ACC_SUM: begin
            cmd      = CMD_ACC_SUM;
            state_in = S_ACC_CLAMP;
         end
         S_ACC_CLAMP: begin
            cmd      = CMD_ACC_CLAMP;
            state_in = S_MUL_P;
         end
         S_MUL_P: begin
            cmd      = CMD_MUL_P;
            state_in = S_P_SAVE;
         end
         S_P_SAVE: begin
            cmd      = CMD_P_SAVE;
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            cmd      = CMD_MUL_D;
            state_in = S_MAG_SAVE;
         end
         S_MAG_SAVE: begin
            cmd      = CMD_MAG_SAVE;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd      = CMD_DIV_INIT;
            cnt_in   = '0;
            state_in = stat.div_skip ? S_FINISH : S_DIV_STEP;
         end
         S_DIV_STEP: begin
            cmd    = CMD_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the result register is free
            if (!stat.rsp_busy) begin
               cmd      = CMD_FINISH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/pid_controller_step.sv =====
// Top level of the PID controller step block.
//
// One input beat carries an error sample and a time step (both Q16.16).
// The block updates its trapezoidal integral (with optional anti-windup
// clamp), forms P + I + D and returns one result beat: the saturated drive
// value and a flag telling whether saturation occurred.
// The request channel is stalled while an item is in progress; the block
// works on one item at a time and accepts the next beat once the sequencer
// has written the result register and returned to idle. The 49-step
// restoring divider for the derivative term takes up most of each item; it
// is skipped when the time step is zero or the derivative quotient is too
// large for the divider, in which case the quotient is clamped.
// A result register sits on the output, so a new beat is accepted while a
// finished result waits; if the receiver still stalls when the next result
// is ready, the sequencer holds in its last step until the register frees.
// Synchronous reset clears the integral, the previous error and both
// channels, and restores the register defaults. Configuration writes take
// effect at the next edge and are expected only while the block is idle.
module pid_controller_step
   import pidc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_error_sample,
   input  logic [31:0]          req_step_time,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_drive_value,
   output logic                 rsp_out_saturated,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   pidc_cfg_type  cfg;
   pidc_cmd_type  cmd;
   pidc_stat_type stat;

   pidc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pidc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pidc_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .stat              (stat),
      .req_error_sample  (req_error_sample),
      .req_step_time     (req_step_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drive_value   (rsp_drive_value),
      .rsp_out_saturated (rsp_out_saturated)
   );

endmodule

// ===== hw/rtl/pidc_checker.sv =====
// Port-level checks for the PID controller step block, bound to the top level.
module pidc_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic signed [31:0]   rsp_drive_value,
   input  logic                 rsp_out_saturated
);

   logic req_beat;
   assign req_beat = req_valid && !req_stall;

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive_value)
                                 && $stable(rsp_out_saturated))
      else $error("stalled result beat changed");

   // One item at a time: an accepted beat closes the request channel
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> req_stall)
      else $error("request not stalled after accepting a beat");

   // A saturated result sits at one of the range limits
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_saturated |->
         (rsp_drive_value == {1'b0, {31{1'b1}}}) ||
         (rsp_drive_value == {1'b1, {31{1'b0}}}))
      else $error("saturation flag without a limit value");

   // No result can appear right after an accept
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after accept");

   // Reset leaves both channels empty and the request side open
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("channels not cleared by reset");

endmodule

bind pid_controller_step pidc_checker u_pidc_checker (.*);

// ===== tb/sv/tb_pid_controller_step.sv =====
// Self-checking testbench for the PID controller step block.
module tb_pid_controller_step;
   import pidc_pkg::*;

   // Spare register indexes: writes to these must leave the gains untouched
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   localparam int          CYCLE_LIMIT   = 1000000;
   localparam int          RAND_PHASES   = 6;
   localparam int          PHASE_STEPS   = 250;
   localparam int          HOLD_CYCLES   = 500;
   localparam int          HOLD_SPACING  = 700;
   localparam int          TAIL_CYCLES   = 80;
   localparam logic [31:0] Q_MAX         = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN         = 32'h8000_0000;
   localparam logic [31:0] Q_ONE         = 32'h0001_0000;
   localparam longint      S32_TOP       = 64'sd2147483647;
   localparam longint      S32_BOTTOM    = -64'sd2147483648;

   typedef struct packed {
      logic signed [31:0] drive;
      logic               sat;
   } drive_rec_type;

   // One line of the directed script: a register write or a step
   typedef struct packed {
      logic                 wr;
      logic [CSR_IDX_W-1:0] idx;
      logic [31:0]          a;
      logic [31:0]          b;
      logic                 typed;
      logic [31:0]          want;
      logic                 want_sat;
   } script_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [31:0]   req_error_sample;
   logic [31:0]          req_step_time;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [31:0]   rsp_drive_value;
   logic                 rsp_out_saturated;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;

   // Controller copy: gains, clamp limits and the two state words
   pidc_cfg_type       ctl_cfg;
   logic signed [31:0] integ_state;
   logic signed [31:0] prev_err;

   drive_rec_type  pending_drives[$];
   script_row_type script[$];

   int  fail_count   = 0;
   int  items_sent   = 0;
   int  drives_seen  = 0;
   int  cycle_count  = 0;
   int  holds_done   = 0;
   int  hold_left    = 0;
   int  next_hold_at = 200;
   bit  quiet        = 1'b0;

   pid_controller_step u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_error_sample  (req_error_sample),
      .req_step_time     (req_step_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drive_value   (rsp_drive_value),
      .rsp_out_saturated (rsp_out_saturated),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Clip a wide value to the signed 32-bit range
   function automatic longint clip32(input longint v);
      if (v > S32_TOP) begin
         return S32_TOP;
      end else if (v < S32_BOTTOM) begin
         return S32_BOTTOM;
      end
      return v;
   endfunction

   // Work out the drive value for one step and advance the controller copy
   function automatic drive_rec_type next_drive(input logic [31:0] e_bits,
                                                input logic [31:0] dt_bits);
      longint          e, prev, avg, kdt, inc, acc, p, d, y, diff, kd;
      longint unsigned dtu, q, mk, md;
      logic            neg;
      drive_rec_type   r;
      e    = longint'($signed(e_bits));
      prev = longint'(prev_err);
      dtu  = {32'd0, dt_bits};
      kd   = longint'($signed(ctl_cfg.kd_gain));

      // trapezoidal integral, then optional anti-windup clamp
      avg = (e + prev) >>> 1;
      kdt = clip32((longint'($signed(ctl_cfg.ki_gain)) * longint'(dtu)) >>> 16);
      inc = (kdt * avg) >>> 16;
      acc = clip32(longint'(integ_state) + inc);
      if (ctl_cfg.clamp_enable) begin
         if (acc < longint'($signed(ctl_cfg.wind_min)))
            acc = longint'($signed(ctl_cfg.wind_min));
         if (acc > longint'($signed(ctl_cfg.wind_max)))
            acc = longint'($signed(ctl_cfg.wind_max));
      end
      integ_state = acc[31:0];

      p = (longint'($signed(ctl_cfg.kp_gain)) * e) >>> 16;

      // derivative: magnitude quotient truncated toward zero, capped at 2^48
      d = 0;
      if (dtu != 0) begin
         diff = e - prev;
         neg  = (kd < 0) != (diff < 0);
         mk   = (kd < 0) ? -kd : kd;
         md   = (diff < 0) ? -diff : diff;
         q    = (mk * md) / dtu;
         if (q > (64'd1 << 48)) q = 64'd1 << 48;
         d = neg ? -longint'(q) : longint'(q);
      end
      prev_err = e_bits;

      y       = p + acc + d;
      r.sat   = (y > S32_TOP) || (y < S32_BOTTOM);
      r.drive = 32'(clip32(y));
      return r;
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      case (idx)
         REG_KP_GAIN:      ctl_cfg.kp_gain      = val;
         REG_KI_GAIN:      ctl_cfg.ki_gain      = val;
         REG_KD_GAIN:      ctl_cfg.kd_gain      = val;
         REG_WIND_MIN:     ctl_cfg.wind_min     = val;
         REG_WIND_MAX:     ctl_cfg.wind_max     = val;
         REG_CLAMP_ENABLE: ctl_cfg.clamp_enable = val[0];
         default: ;
      endcase
   endfunction

   function automatic void add_wr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      script.push_back('{1'b1, idx, val, 32'd0, 1'b0, 32'd0, 1'b0});
   endfunction

   function automatic void add_step(input logic [31:0] e, input logic [31:0] dt);
      script.push_back('{1'b0, REG_KP_GAIN, e, dt, 1'b0, 32'd0, 1'b0});
   endfunction

   function automatic void add_chk(input logic [31:0] e, input logic [31:0] dt,
                                   input logic [31:0] want, input logic want_sat);
      script.push_back('{1'b0, REG_KP_GAIN, e, dt, 1'b1, want, want_sat});
   endfunction

   function automatic logic [31:0] pick_gain();
      logic [31:0] g;
      case ($urandom_range(3))
         0: g = $urandom_range(1) ? Q_MAX : Q_MIN;
         1: begin
            g = $urandom_range(32'h0002_0000);
            if ($urandom_range(1)) g = -g;
         end
         default: g = $urandom();
      endcase
      return g;
   endfunction

   function automatic logic [31:0] pick_error();
      logic [31:0] v;
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0: v = Q_MAX;
               1: v = Q_MIN;
               2: v = 32'd0;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
         1, 2, 3: v = $urandom();
         default: begin
            v = $urandom_range(32'h0004_0000);
            if ($urandom_range(1)) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic logic [31:0] pick_dt();
      logic [31:0] v;
      case ($urandom_range(9))
         0: v = 32'd0;
         1: v = 32'hFFFF_FFFF;
         2, 3: v = $urandom();
         default: v = $urandom_range(32'h0002_0000, 1);
      endcase
      return v;
   endfunction

   // Drive one register write, then drop the enable on the following cycle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      apply_reg(idx, val);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Withdraw the request and wait until every expected drive has returned
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Offer one step beat; hold it until accepted, then queue its drive value
   task automatic offer_step(input logic [31:0] e, input logic [31:0] dt, input logic typed,
                             input logic [31:0] want, input logic want_sat);
      drive_rec_type due;
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_error_sample <= e;
      req_step_time    <= dt;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      due = next_drive(e, dt);
      if (typed) begin
         due.drive = want;
         due.sat   = want_sat;
      end
      pending_drives.push_back(due);
      items_sent++;
   endtask

   // Receiver: random stalls, quiet stretches and long hold-offs
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && items_sent >= next_hold_at) begin
            hold_left    = HOLD_CYCLES;
            next_hold_at = next_hold_at + HOLD_SPACING;
            holds_done++;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 8);
         end
      end
   end

   // Compare each accepted drive beat with the oldest expectation
   always @(posedge clock) begin
      drive_rec_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         drives_seen++;
         if (pending_drives.size() == 0) begin
            $error("unexpected drive beat: drive_value %h out_saturated %b",
                   rsp_drive_value, rsp_out_saturated);
            fail_count++;
         end else begin
            due = pending_drives.pop_front();
            if (rsp_drive_value !== due.drive) begin
               $error("drive_value mismatch: expected %h, actual %h", due.drive,
                      rsp_drive_value);
               fail_count++;
            end
            if (rsp_out_saturated !== due.sat) begin
               $error("out_saturated mismatch: expected %b, actual %b", due.sat,
                      rsp_out_saturated);
               fail_count++;
            end
         end
      end
   end

   // Guard against a hung block
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      script_row_type row;
      logic [31:0] kp, ki, kd, wmin, wmax, wide;
      logic        clamp;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_error_sample = '0;
      req_step_time    = '0;
      csr_wr_en        = 1'b0;
      csr_index        = REG_KP_GAIN;
      csr_wdata        = '0;
      ctl_cfg          = '{32'd0, 32'd0, 32'd0, Q_MIN, Q_MAX, 1'b1};
      integ_state      = '0;
      prev_err         = '0;

      // reset defaults: all gains zero, so the drive is zero
      add_chk(Q_MAX, 32'd0, 32'd0, 1'b0);
      add_chk(Q_MIN, 32'hFFFF_FFFF, 32'd0, 1'b0);
      // unity proportional gain passes the error through
      add_wr(REG_KP_GAIN, Q_ONE);
      add_chk(Q_MAX, 32'd0, Q_MAX, 1'b0);
      add_chk(Q_MIN, Q_ONE, Q_MIN, 1'b0);
      // largest proportional gain saturates both ways
      add_wr(REG_KP_GAIN, Q_MAX);
      add_chk(Q_MAX, 32'd0, Q_MAX, 1'b1);
      add_chk(Q_MIN, 32'd0, Q_MIN, 1'b1);
      add_chk(32'd0, 32'd0, 32'd0, 1'b0);
      // integral alone, wound up to the top of the range
      add_wr(REG_KP_GAIN, 32'd0);
      add_wr(REG_KI_GAIN, Q_ONE);
      add_step(Q_ONE, Q_ONE);
      add_step(Q_MAX, 32'hFFFF_FFFF);
      // anti-windup limits of plus and minus sixteen
      add_wr(REG_WIND_MIN, 32'hFFF0_0000);
      add_wr(REG_WIND_MAX, 32'h0010_0000);
      add_chk(Q_MAX, 32'hFFFF_FFFF, 32'h0010_0000, 1'b0);
      add_step(Q_MIN, 32'hFFFF_FFFF);
      add_chk(Q_MIN, 32'hFFFF_FFFF, 32'hFFF0_0000, 1'b0);
      // zero time step leaves the integral where it was
      add_chk(32'h1234_5678, 32'd0, 32'hFFF0_0000, 1'b0);
      // inverted limits settle on the upper limit
      add_wr(REG_WIND_MIN, 32'h0020_0000);
      add_wr(REG_WIND_MAX, 32'hFFE0_0000);
      add_chk(32'd0, 32'd0, 32'hFFE0_0000, 1'b0);
      // clamp off: upper data bits must not matter
      add_wr(REG_CLAMP_ENABLE, 32'hFFFF_FFFE);
      add_step(Q_MAX, 32'hFFFF_FFFF);
      add_step(Q_MAX, 32'hFFFF_FFFF);
      // spare indexes are ignored
      add_wr(REG_SPARE_LO, Q_MAX);
      add_wr(REG_SPARE_HI, 32'hFFFF_FFFF);
      // derivative alone, including the shortest step and the most negative gain
      add_wr(REG_KI_GAIN, 32'd0);
      add_wr(REG_KD_GAIN, Q_ONE);
      add_wr(REG_CLAMP_ENABLE, 32'd1);
      add_wr(REG_WIND_MIN, Q_MIN);
      add_wr(REG_WIND_MAX, Q_MAX);
      add_step(Q_ONE, Q_ONE);
      add_step(Q_MIN, 32'd1);
      add_step(Q_MAX, 32'd1);
      add_step(Q_MAX, 32'hFFFF_FFFF);
      add_wr(REG_KD_GAIN, Q_MIN);
      add_step(Q_MIN, 32'd1);
      add_step(Q_MAX, 32'd3);
      // all three terms at once
      add_wr(REG_KD_GAIN, Q_MAX);
      add_wr(REG_KP_GAIN, Q_MIN);
      add_wr(REG_KI_GAIN, Q_MIN);
      add_step(32'h5555_5555, 32'hAAAA_AAAA);
      add_step(32'hAAAA_AAAA, 32'h5555_5555);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // walk the directed script
      foreach (script[i]) begin
         row = script[i];
         if (row.wr) begin
            settle_block();
            write_reg(row.idx, row.a);
         end else begin
            offer_step(row.a, row.b, row.typed, row.want, row.want_sat);
         end
      end

      // random phases, each under its own gain setting
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         settle_block();
         case (ph)
            0: begin
               kp = Q_MAX; ki = Q_MAX; kd = Q_MAX; wmin = Q_MIN; wmax = Q_MAX; clamp = 1'b1;
            end
            1: begin
               kp = Q_MIN; ki = Q_MIN; kd = Q_MIN; wmin = Q_MAX; wmax = Q_MIN; clamp = 1'b1;
            end
            default: begin
               kp    = pick_gain();
               ki    = pick_gain();
               kd    = pick_gain();
               clamp = $urandom_range(3) != 0;
               case ($urandom_range(3))
                  0: begin
                     wmin = Q_MIN;
                     wmax = Q_MAX;
                  end
                  1: begin
                     wmax = $urandom_range(32'h0100_0000);
                     wmin = -wmax;
                  end
                  2: begin
                     wmin = $urandom_range(32'h0080_0000, 1);
                     wmax = -wmin;
                  end
                  default: begin
                     wmin = $urandom();
                     wmax = $urandom();
                  end
               endcase
            end
         endcase
         wide = $urandom();
         write_reg(REG_KP_GAIN, kp);
         write_reg(REG_KI_GAIN, ki);
         write_reg(REG_KD_GAIN, kd);
         write_reg(REG_WIND_MIN, wmin);
         write_reg(REG_WIND_MAX, wmax);
         write_reg(REG_CLAMP_ENABLE, {wide[31:1], clamp});
         if ($urandom_range(1)) write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                                          $urandom());
         // one phase runs without random idle cycles on either side; long hold-offs still apply
         quiet = (ph == 2);
         for (int n = 0; n < PHASE_STEPS; n++) begin
            offer_step(pick_error(), pick_dt(), 1'b0, 32'd0, 1'b0);
         end
         quiet = 1'b0;
      end

      // drain and allow for a stray late beat
      settle_block();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d controller steps over %0d random gain settings plus a directed set;",
               items_sent, RAND_PHASES);
      $display("%0d drive beats checked, %0d long receiver hold-offs, %0d still expected.",
               drives_seen, holds_done, pending_drives.size());
      if (fail_count == 0 && pending_drives.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/pidc_pkg.sv
hw/rtl/pidc_csr.sv
hw/rtl/pidc_datapath.sv
hw/rtl/pidc_ctrl.sv
hw/rtl/pid_controller_step.sv
hw/rtl/pidc_checker.sv
tb/sv/tb_pid_controller_step.sv
